// ===== rtl/core/atsf_pkg.sv =====
package atsf_pkg;

  // Parse phases of one tag field.
  typedef enum logic [2:0] {
    PH_TAG0,
    PH_TAG1,
    PH_TYPE,
    PH_FIXED,
    PH_STRING,
    PH_SUBTYPE,
    PH_COUNT
  } phase_t;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TRUNC    = 2'd1;
  localparam logic [1:0] ST_BAD_TYPE = 2'd2;
  localparam logic [1:0] ST_BAD_SUB  = 2'd3;

  // Character codes used by the parser.
  localparam logic [7:0] CH_UP_M = 8'h4D;  // M
  localparam logic [7:0] CH_UP_Q = 8'h51;  // Q
  localparam logic [7:0] CH_UP_C = 8'h43;  // C
  localparam logic [7:0] CH_LO_M = 8'h6D;  // m
  localparam logic [7:0] CH_LO_S = 8'h73;  // s
  localparam logic [7:0] CH_UP_Z = 8'h5A;  // Z
  localparam logic [7:0] CH_UP_H = 8'h48;  // H
  localparam logic [7:0] CH_UP_B = 8'h42;  // B
  localparam logic [7:0] CH_LO_D = 8'h64;  // d
  localparam logic [7:0] CH_LO_I = 8'h69;  // i
  localparam logic [7:0] CH_LO_F = 8'h66;  // f
  localparam logic [7:0] CH_UP_A = 8'h41;  // A
  localparam logic [7:0] CH_LO_C = 8'h63;  // c
  localparam logic [7:0] CH_UP_S = 8'h53;  // S
  localparam logic [7:0] CH_UP_I = 8'h49;  // I
  localparam logic [7:0] CH_NUL  = 8'h00;

  // Result queue geometry.
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  data;
    logic        run_last;
    logic        record_done;
    logic [1:0]  status;
    logic [31:0] kept_length;
  } result_t;

  // Up to two results written to the queue per accepted request.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } rq_push_t;

  // Element width in bytes of an array subtype; zero for an unknown code.
  function automatic logic [3:0] elem_width(input logic [7:0] c);
    logic [3:0] w;
    w = 4'd0;
    case (c)
      CH_LO_C, CH_UP_C:          w = 4'd1;
      CH_LO_S, CH_UP_S:          w = 4'd2;
      CH_LO_I, CH_UP_I, CH_LO_F: w = 4'd4;
      CH_LO_D:                   w = 4'd8;
      default:                   w = 4'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/atsf_parser.sv =====
module atsf_parser
  import atsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     acc,
  input  logic [7:0] aux_byte,
  input  logic     region_end,
  input  logic     drop_mq,
  input  logic     drop_mc,
  input  logic     drop_ms,
  output rq_push_t push
);

  phase_t       phase_r, phase_nxt;
  logic [7:0]   held_r, held_nxt;
  logic         dropped_r, dropped_nxt;
  logic [3:0]   aw_r, aw_nxt;
  logic [1:0]   cbs_r, cbs_nxt;
  logic [31:0]  ac_r, ac_nxt;
  logic [34:0]  pl_r, pl_nxt;
  logic [1:0]   err_r, err_nxt;
  logic [31:0]  kept_r, kept_nxt;

  logic         emit_a, emit_b, drop_new;
  logic [7:0]   data_a;
  logic [1:0]   err_step;
  logic [31:0]  ac_new, kept_a, kept_b;
  logic [34:0]  pl_dec, pl_arr;
  logic [3:0]   type_w;
  logic         is_str, is_arr;

  function automatic logic [31:0] sat_inc(input logic [31:0] k);
    return (k == 32'hFFFF_FFFF) ? k : k + 32'd1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_TAG0;
      held_r    <= 8'd0;
      dropped_r <= 1'b0;
      aw_r      <= 4'd0;
      cbs_r     <= 2'd0;
      ac_r      <= 32'd0;
      pl_r      <= 35'd0;
      err_r     <= ST_OK;
      kept_r    <= 32'd0;
    end else if (acc) begin
      phase_r   <= phase_nxt;
      held_r    <= held_nxt;
      dropped_r <= dropped_nxt;
      aw_r      <= aw_nxt;
      cbs_r     <= cbs_nxt;
      ac_r      <= ac_nxt;
      pl_r      <= pl_nxt;
      err_r     <= err_nxt;
      kept_r    <= kept_nxt;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    held_nxt    = held_r;
    dropped_nxt = dropped_r;
    aw_nxt      = aw_r;
    cbs_nxt     = cbs_r;
    ac_nxt      = ac_r;
    pl_nxt      = pl_r;
    err_step    = err_r;
    emit_a      = 1'b0;
    emit_b      = 1'b0;
    data_a      = aux_byte;
    drop_new    = dropped_r;

    ac_new = ac_r | ({24'd0, aux_byte} << {cbs_r, 3'b000});
    pl_dec = (pl_r != 35'd0) ? pl_r - 35'd1 : pl_r;
    case (aw_r)
      4'd1:    pl_arr = {3'd0, ac_new};
      4'd2:    pl_arr = {2'd0, ac_new, 1'b0};
      4'd4:    pl_arr = {1'd0, ac_new, 2'b00};
      4'd8:    pl_arr = {ac_new, 3'b000};
      default: pl_arr = 35'd0;
    endcase
    type_w = (aux_byte == CH_UP_A) ? 4'd1 : elem_width(aux_byte);
    is_str = (aux_byte == CH_UP_Z) || (aux_byte == CH_UP_H);
    is_arr = (aux_byte == CH_UP_B);

    if (err_r == ST_OK) begin
      unique case (phase_r)
        PH_TAG1: begin
          if (region_end) begin
            err_step = ST_TRUNC;
          end else begin
            drop_new = (drop_mq && held_r == CH_UP_M && aux_byte == CH_UP_Q) ||
                       (drop_mc && held_r == CH_UP_M && aux_byte == CH_UP_C) ||
                       (drop_ms && held_r == CH_LO_M && aux_byte == CH_LO_S);
            dropped_nxt = drop_new;
            emit_a      = !drop_new;
            emit_b      = !drop_new;
            data_a      = held_r;
            phase_nxt   = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (type_w == 4'd0 && !is_str && !is_arr) begin
            err_step = ST_BAD_TYPE;
          end else if (region_end) begin
            err_step = ST_TRUNC;
          end else begin
            emit_a = !dropped_r;
            if (is_str) begin
              phase_nxt = PH_STRING;
            end else if (is_arr) begin
              phase_nxt = PH_SUBTYPE;
            end else begin
              pl_nxt    = {31'd0, type_w};
              phase_nxt = PH_FIXED;
            end
          end
        end
        PH_FIXED: begin
          pl_nxt = pl_dec;
          if (region_end && pl_dec != 35'd0) begin
            err_step = ST_TRUNC;
          end else begin
            emit_a = !dropped_r;
            if (pl_dec == 35'd0) begin
              phase_nxt = PH_TAG0;
            end
          end
        end
        PH_STRING: begin
          if (region_end && aux_byte != CH_NUL) begin
            err_step = ST_TRUNC;
          end else begin
            emit_a = !dropped_r;
            if (aux_byte == CH_NUL) begin
              phase_nxt = PH_TAG0;
            end
          end
        end
        PH_SUBTYPE: begin
          if (region_end) begin
            err_step = ST_TRUNC;
          end else begin
            aw_nxt    = elem_width(aux_byte);
            cbs_nxt   = 2'd0;
            ac_nxt    = 32'd0;
            emit_a    = !dropped_r;
            phase_nxt = PH_COUNT;
          end
        end
        PH_COUNT: begin
          ac_nxt = ac_new;
          if (cbs_r != 2'd3) begin
            if (region_end) begin
              err_step = ST_TRUNC;
            end else begin
              cbs_nxt = cbs_r + 2'd1;
              emit_a  = !dropped_r;
            end
          end else if (aw_r == 4'd0) begin
            err_step = ST_BAD_SUB;
          end else begin
            pl_nxt = pl_arr;
            if (pl_arr == 35'd0) begin
              emit_a    = !dropped_r;
              phase_nxt = PH_TAG0;
            end else if (region_end) begin
              err_step = ST_TRUNC;
            end else begin
              emit_a    = !dropped_r;
              phase_nxt = PH_FIXED;
            end
          end
        end
        default: begin
          if (region_end) begin
            err_step = ST_TRUNC;
          end else begin
            held_nxt  = aux_byte;
            phase_nxt = PH_TAG1;
          end
        end
      endcase
    end

    kept_a = sat_inc(kept_r);
    kept_b = sat_inc(kept_a);

    // First slot: a kept byte, or the closing marker when nothing was kept.
    push.res0.byte_valid  = emit_a;
    push.res0.data        = emit_a ? data_a : 8'd0;
    push.res0.run_last    = !emit_b;
    push.res0.record_done = region_end && !emit_b;
    push.res0.status      = (region_end && !emit_b) ? err_step : err_r;
    push.res0.kept_length = emit_a ? kept_a : kept_r;

    push.res1.byte_valid  = 1'b1;
    push.res1.data        = aux_byte;
    push.res1.run_last    = 1'b1;
    push.res1.record_done = region_end;
    push.res1.status      = region_end ? err_step : err_r;
    push.res1.kept_length = kept_b;

    if (!acc) begin
      push.cnt = 2'd0;
    end else if (emit_b) begin
      push.cnt = 2'd2;
    end else if (emit_a || region_end) begin
      push.cnt = 2'd1;
    end else begin
      push.cnt = 2'd0;
    end

    err_nxt  = err_step;
    kept_nxt = emit_b ? kept_b : (emit_a ? kept_a : kept_r);

    // Closing a record returns every state element to its reset value.
    if (region_end) begin
      phase_nxt   = PH_TAG0;
      held_nxt    = 8'd0;
      dropped_nxt = 1'b0;
      aw_nxt      = 4'd0;
      cbs_nxt     = 2'd0;
      ac_nxt      = 32'd0;
      pl_nxt      = 35'd0;
      err_nxt     = ST_OK;
      kept_nxt    = 32'd0;
    end
  end

endmodule

// ===== rtl/core/atsf_result_fifo.sv =====
module atsf_result_fifo
  import atsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  rq_push_t push,
  output logic     space_ok,
  output logic     rd_valid,
  input  logic     rd_ready,
  output result_t  rd_data
);

  result_t               mem_r [RQ_DEPTH];
  logic [RQ_PTR_W-1:0]   wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [RQ_CNT_W-1:0]   count_r, count_nxt;
  logic                  pop;

  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rptr_r];
  assign pop      = rd_valid && rd_ready;
  assign space_ok = (count_r <= RQ_CNT_W'(RQ_DEPTH - 2));

  always_comb begin
    wptr_nxt  = wptr_r + RQ_PTR_W'(push.cnt);
    rptr_nxt  = rptr_r + RQ_PTR_W'(pop);
    count_nxt = count_r + RQ_CNT_W'(push.cnt) - RQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wptr_r] <= push.res0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wptr_r + RQ_PTR_W'(1)] <= push.res1;
    end
  end

endmodule

// ===== rtl/core/aux_tag_stream_filter_core.sv =====
// Auxiliary tag stream filter.
// Input channel (in_valid/in_ready): one byte of a record's auxiliary-tag
// region per request, with in_region_end on the record's last byte and the
// three drop flags, which are sampled at the second tag byte of each field.
// Result channel (out_valid/out_ready): zero, one or two results per request,
// each carrying a kept byte or a closing marker, the run-last and record-done
// flags, the status and the saturating kept length of the record so far.
// The input takes one byte per cycle while the result queue has room; a
// second tag byte of a kept field gives two results. The parser works
// straight off the accepted byte and writes into a four-entry result
// queue, which registers them; in_ready is high while the queue has room
// for two results, so the input keeps flowing while the receiver takes
// results and stalls only when more than two results wait.
// A stalled receiver simply holds the head result; nothing is lost.
// Reset clears the parse state and empties the queue; no result is pending
// after reset and the first byte starts a new record.
module aux_tag_stream_filter_core
  import atsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_aux_byte,
  input  logic        in_region_end,
  input  logic        in_drop_mate_quality,
  input  logic        in_drop_mate_cigar,
  input  logic        in_drop_mate_score,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_byte_valid,
  output logic [7:0]  out_data,
  output logic        out_run_last,
  output logic        out_record_done,
  output logic [1:0]  out_status,
  output logic [31:0] out_kept_length
);

  rq_push_t push;
  result_t  head;
  logic     space_ok;
  logic     acc;

  // A request is taken whenever the queue can absorb its worst case.
  assign in_ready = space_ok;
  assign acc      = in_valid && space_ok;

  atsf_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .aux_byte   (in_aux_byte),
    .region_end (in_region_end),
    .drop_mq    (in_drop_mate_quality),
    .drop_mc    (in_drop_mate_cigar),
    .drop_ms    (in_drop_mate_score),
    .push       (push)
  );

  atsf_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (head)
  );

  // The queue head drives the result ports directly.
  assign out_byte_valid  = head.byte_valid;
  assign out_data        = head.data;
  assign out_run_last    = head.run_last;
  assign out_record_done = head.record_done;
  assign out_status      = head.status;
  assign out_kept_length = head.kept_length;

endmodule

// ===== test/aux_tag_stream_filter_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the aux tag filter, predicts the results of each
// accepted request and compares them in order with what comes out.
module aux_tag_stream_filter_checker
  import atsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_aux_byte,
  input  logic        in_region_end,
  input  logic        in_drop_mate_quality,
  input  logic        in_drop_mate_cigar,
  input  logic        in_drop_mate_score,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_byte_valid,
  input  logic [7:0]  out_data,
  input  logic        out_run_last,
  input  logic        out_record_done,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_kept_length,
  output int          error_count,
  output int          pending_count,
  output int          result_count,
  output int          record_count
);

  // Parser state of the prediction.
  phase_t      phase_q;
  logic [7:0]  held_tag_q;
  logic        drop_q;
  logic [3:0]  elem_w_q;
  logic [1:0]  count_seen_q;
  logic [31:0] elem_count_q;
  logic [34:0] payload_left_q;
  logic [1:0]  err_q;
  logic [31:0] kept_q;

  result_t expected_q[$];
  result_t step_res[2];
  int      step_n;
  int      errs = 0;
  int      results = 0;
  int      records = 0;

  function automatic logic [3:0] subtype_width(input logic [7:0] c);
    if (c == CH_LO_C || c == CH_UP_C) return 4'd1;
    if (c == CH_LO_S || c == CH_UP_S) return 4'd2;
    if (c == CH_LO_I || c == CH_UP_I || c == CH_LO_F) return 4'd4;
    if (c == CH_LO_D) return 4'd8;
    return 4'd0;
  endfunction

  task automatic clear_parse();
    phase_q        = PH_TAG0;
    held_tag_q     = 8'h00;
    drop_q         = 1'b0;
    elem_w_q       = 4'd0;
    count_seen_q   = 2'd0;
    elem_count_q   = 32'd0;
    payload_left_q = 35'd0;
    err_q          = ST_OK;
    kept_q         = 32'd0;
  endtask

  task automatic add_result(input logic kept, input logic [7:0] d);
    result_t r;
    if (kept && kept_q != 32'hFFFF_FFFF) kept_q = kept_q + 32'd1;
    r             = '0;
    r.byte_valid  = kept;
    r.data        = kept ? d : 8'h00;
    r.status      = err_q;
    r.kept_length = kept_q;
    step_res[step_n] = r;
    step_n++;
  endtask

  task automatic pass_byte(input logic [7:0] d);
    if (!drop_q) add_result(1'b1, d);
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic fin, input logic dmq,
                              input logic dmc, input logic dms);
    logic [3:0] w;
    logic       is_str;
    logic       is_arr;
    step_n = 0;
    if (err_q == ST_OK) begin
      case (phase_q)
        PH_TAG1: begin
          if (fin) begin
            err_q = ST_TRUNC;
          end else begin
            drop_q = (dmq && held_tag_q == CH_UP_M && b == CH_UP_Q) ||
                     (dmc && held_tag_q == CH_UP_M && b == CH_UP_C) ||
                     (dms && held_tag_q == CH_LO_M && b == CH_LO_S);
            pass_byte(held_tag_q);
            pass_byte(b);
            phase_q = PH_TYPE;
          end
        end
        PH_TYPE: begin
          w      = (b == CH_UP_A) ? 4'd1 : subtype_width(b);
          is_str = (b == CH_UP_Z) || (b == CH_UP_H);
          is_arr = (b == CH_UP_B);
          if (w == 4'd0 && !is_str && !is_arr) begin
            err_q = ST_BAD_TYPE;
          end else if (fin) begin
            err_q = ST_TRUNC;
          end else begin
            pass_byte(b);
            if (is_str) begin
              phase_q = PH_STRING;
            end else if (is_arr) begin
              phase_q = PH_SUBTYPE;
            end else begin
              payload_left_q = 35'(w);
              phase_q        = PH_FIXED;
            end
          end
        end
        PH_FIXED: begin
          if (payload_left_q != 35'd0) payload_left_q = payload_left_q - 35'd1;
          if (fin && payload_left_q != 35'd0) begin
            err_q = ST_TRUNC;
          end else begin
            pass_byte(b);
            if (payload_left_q == 35'd0) phase_q = PH_TAG0;
          end
        end
        PH_STRING: begin
          if (fin && b != CH_NUL) begin
            err_q = ST_TRUNC;
          end else begin
            pass_byte(b);
            if (b == CH_NUL) phase_q = PH_TAG0;
          end
        end
        PH_SUBTYPE: begin
          if (fin) begin
            err_q = ST_TRUNC;
          end else begin
            elem_w_q     = subtype_width(b);
            count_seen_q = 2'd0;
            elem_count_q = 32'd0;
            pass_byte(b);
            phase_q = PH_COUNT;
          end
        end
        PH_COUNT: begin
          elem_count_q = elem_count_q | (32'(b) << (8 * count_seen_q));
          if (count_seen_q < 2'd3) begin
            if (fin) begin
              err_q = ST_TRUNC;
            end else begin
              count_seen_q = count_seen_q + 2'd1;
              pass_byte(b);
            end
          end else if (elem_w_q == 4'd0) begin
            err_q = ST_BAD_SUB;
          end else begin
            payload_left_q = 35'(elem_count_q) * 35'(elem_w_q);
            if (payload_left_q == 35'd0) begin
              pass_byte(b);
              phase_q = PH_TAG0;
            end else if (fin) begin
              err_q = ST_TRUNC;
            end else begin
              pass_byte(b);
              phase_q = PH_FIXED;
            end
          end
        end
        default: begin
          if (fin) begin
            err_q = ST_TRUNC;
          end else begin
            held_tag_q = b;
            phase_q    = PH_TAG1;
          end
        end
      endcase
    end
    // The last byte of a region always closes the record, with an empty
    // marker result when nothing else came out of it.
    if (fin) begin
      if (step_n == 0) add_result(1'b0, 8'h00);
      step_res[step_n-1].record_done = 1'b1;
      step_res[step_n-1].status      = err_q;
      clear_parse();
    end
    if (step_n > 0) step_res[step_n-1].run_last = 1'b1;
    for (int i = 0; i < step_n; i++) expected_q.push_back(step_res[i]);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      clear_parse();
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        results++;
        if (out_record_done === 1'b1) records++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual data %0h kept %0h",
                   $time, out_data, out_kept_length);
          errs++;
        end else begin
          want = expected_q.pop_front();
          check_field("byte_valid", 32'(want.byte_valid), 32'(out_byte_valid));
          check_field("data", 32'(want.data), 32'(out_data));
          check_field("run_last", 32'(want.run_last), 32'(out_run_last));
          check_field("record_done", 32'(want.record_done), 32'(out_record_done));
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("kept_length", want.kept_length, out_kept_length);
        end
      end
      if (in_valid && in_ready) begin
        predict_byte(in_aux_byte, in_region_end, in_drop_mate_quality,
                     in_drop_mate_cigar, in_drop_mate_score);
      end
    end
    error_count   <= errs;
    pending_count <= expected_q.size();
    result_count  <= results;
    record_count  <= records;
  end

endmodule

// ===== test/aux_tag_stream_filter_core_tb.sv =====
`timescale 1ns / 1ps

module aux_tag_stream_filter_core_tb;
  import atsf_pkg::*;

  // Number of random requests after the directed records.
  localparam int RANDOM_REQUESTS = 1200;
  // Cycles without any accepted request on either channel before the run
  // is declared hung. The longest legal quiet stretch is the receiver
  // hold-off below plus a few gaps.
  localparam int STALL_LIMIT = 3000;
  // Length of the one long receiver hold-off, and the result count at
  // which it starts.
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AT = 250;
  // Requests sent before the sender stops once and lets the block drain.
  localparam int DRAIN_AT = 600;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_aux_byte;
  logic        in_region_end;
  logic        in_drop_mate_quality;
  logic        in_drop_mate_cigar;
  logic        in_drop_mate_score;
  logic        out_valid;
  logic        out_ready;
  logic        out_byte_valid;
  logic [7:0]  out_data;
  logic        out_run_last;
  logic        out_record_done;
  logic [1:0]  out_status;
  logic [31:0] out_kept_length;

  int error_count;
  int pending_count;
  int result_count;
  int record_count;

  // Bytes of the record being built, sent in order with region_end on the
  // last one.
  logic [7:0] rec_bytes[$];
  int         sent_count = 0;
  int         rx_taken = 0;
  int         idle_cycles = 0;
  bit         sender_quiet = 1'b0;

  aux_tag_stream_filter_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_aux_byte          (in_aux_byte),
    .in_region_end        (in_region_end),
    .in_drop_mate_quality (in_drop_mate_quality),
    .in_drop_mate_cigar   (in_drop_mate_cigar),
    .in_drop_mate_score   (in_drop_mate_score),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_byte_valid       (out_byte_valid),
    .out_data             (out_data),
    .out_run_last         (out_run_last),
    .out_record_done      (out_record_done),
    .out_status           (out_status),
    .out_kept_length      (out_kept_length)
  );

  // The checker sits beside the block, sees every handshake on both
  // channels and reports how many failures it found and how many results
  // it still waits for.
  aux_tag_stream_filter_checker u_result_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_aux_byte          (in_aux_byte),
    .in_region_end        (in_region_end),
    .in_drop_mate_quality (in_drop_mate_quality),
    .in_drop_mate_cigar   (in_drop_mate_cigar),
    .in_drop_mate_score   (in_drop_mate_score),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_byte_valid       (out_byte_valid),
    .out_data             (out_data),
    .out_run_last         (out_run_last),
    .out_record_done      (out_record_done),
    .out_status           (out_status),
    .out_kept_length      (out_kept_length),
    .error_count          (error_count),
    .pending_count        (pending_count),
    .result_count         (result_count),
    .record_count         (record_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sends one request. The gap before it is drawn per request; a zero gap
  // leaves in_valid high from the previous request, so valid is never
  // dropped and raised within one step.
  task automatic send_byte(input logic [7:0] b, input logic fin, input logic [2:0] drops);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_aux_byte          <= b;
    in_region_end        <= fin;
    in_drop_mate_quality <= drops[0];
    in_drop_mate_cigar   <= drops[1];
    in_drop_mate_score   <= drops[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  // The drop flags stay constant for the whole record.
  task automatic send_record(input logic [2:0] drops);
    for (int i = 0; i < rec_bytes.size(); i++) begin
      send_byte(rec_bytes[i], i == rec_bytes.size() - 1, drops);
    end
  endtask

  // Stops offering and waits until the checker expects nothing more. The
  // first edge lets the checker account for the request just accepted.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Tags lean toward the three droppable ones and their near misses, so
  // the filter decision is exercised often.
  task automatic add_tag();
    case ($urandom_range(0, 6))
      0: begin rec_bytes.push_back(CH_UP_M); rec_bytes.push_back(CH_UP_Q); end
      1: begin rec_bytes.push_back(CH_UP_M); rec_bytes.push_back(CH_UP_C); end
      2: begin rec_bytes.push_back(CH_LO_M); rec_bytes.push_back(CH_LO_S); end
      3: begin rec_bytes.push_back(CH_UP_M); rec_bytes.push_back(any_byte()); end
      4: begin rec_bytes.push_back(CH_LO_M); rec_bytes.push_back(any_byte()); end
      5: begin rec_bytes.push_back(any_byte()); rec_bytes.push_back(any_byte()); end
      default: begin
        rec_bytes.push_back(8'($urandom_range(8'h41, 8'h7A)));
        rec_bytes.push_back(8'($urandom_range(8'h41, 8'h7A)));
      end
    endcase
  endtask

  // Appends one field. When the field cannot be completed sensibly (an
  // unknown type or subtype, or a huge array count) open_ended is set and
  // the record is ended right after it, which leaves it truncated or in
  // error.
  task automatic add_field(output bit open_ended);
    logic [7:0]  code;
    logic [7:0]  sub;
    logic [31:0] count;
    int          width;
    int          sel;
    open_ended = 1'b0;
    width      = 0;
    add_tag();
    sel = $urandom_range(0, 15);
    case (sel)
      0:          begin code = CH_UP_A; width = 1; end
      1:          begin code = CH_LO_C; width = 1; end
      2:          begin code = CH_UP_C; width = 1; end
      3:          begin code = CH_LO_S; width = 2; end
      4:          begin code = CH_UP_S; width = 2; end
      5:          begin code = CH_LO_I; width = 4; end
      6:          begin code = CH_UP_I; width = 4; end
      7:          begin code = CH_LO_F; width = 4; end
      8:          begin code = CH_LO_D; width = 8; end
      9, 10:      code = CH_UP_Z;
      11:         code = CH_UP_H;
      12, 13, 14: code = CH_UP_B;
      default:    code = any_byte();
    endcase
    rec_bytes.push_back(code);
    if (code == CH_UP_Z || code == CH_UP_H) begin
      repeat ($urandom_range(0, 6)) rec_bytes.push_back(8'($urandom_range(1, 255)));
      rec_bytes.push_back(CH_NUL);
    end else if (sel >= 12 && sel <= 14) begin
      case ($urandom_range(0, 8))
        0:       begin sub = CH_LO_C; width = 1; end
        1:       begin sub = CH_UP_C; width = 1; end
        2:       begin sub = CH_LO_S; width = 2; end
        3:       begin sub = CH_UP_S; width = 2; end
        4:       begin sub = CH_LO_I; width = 4; end
        5:       begin sub = CH_UP_I; width = 4; end
        6:       begin sub = CH_LO_F; width = 4; end
        7:       begin sub = CH_LO_D; width = 8; end
        default: begin sub = any_byte(); width = 0; end
      endcase
      rec_bytes.push_back(sub);
      if ($urandom_range(0, 7) == 0) begin
        count      = $urandom();
        open_ended = 1'b1;
      end else begin
        count = 32'($urandom_range(0, 3));
      end
      rec_bytes.push_back(count[7:0]);
      rec_bytes.push_back(count[15:8]);
      rec_bytes.push_back(count[23:16]);
      rec_bytes.push_back(count[31:24]);
      if (open_ended || width == 0) begin
        open_ended = 1'b1;
        repeat ($urandom_range(0, 5)) rec_bytes.push_back(any_byte());
      end else begin
        repeat (int'(count) * width) rec_bytes.push_back(any_byte());
      end
    end else if (sel <= 8) begin
      repeat (width) rec_bytes.push_back(any_byte());
    end else begin
      open_ended = 1'b1;
      repeat ($urandom_range(0, 4)) rec_bytes.push_back(any_byte());
    end
  endtask

  // Most records are well formed with random content; the rest are cut
  // short at a random byte, carry trailing noise, or are pure noise.
  task automatic build_record();
    bit open_ended;
    int fields;
    int keep_len;
    rec_bytes.delete();
    fields = $urandom_range(1, 4);
    for (int i = 0; i < fields; i++) begin
      add_field(open_ended);
      if (open_ended) break;
    end
    case ($urandom_range(0, 9))
      0, 1: begin
        keep_len = $urandom_range(1, rec_bytes.size());
        while (rec_bytes.size() > keep_len) void'(rec_bytes.pop_back());
      end
      2: repeat ($urandom_range(1, 3)) rec_bytes.push_back(any_byte());
      3: begin
        rec_bytes.delete();
        repeat ($urandom_range(1, 10)) rec_bytes.push_back(any_byte());
      end
      default: ;
    endcase
  endtask

  // Receiver: draws a stall before every result, with stretches of no
  // stalls, and once holds off for a long time so the result queue fills
  // and the block has to stall its input.
  initial begin : receiver
    int stall;
    bit burst;
    burst = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_taken % 50 == 0) burst = ($urandom_range(0, 2) == 0);
      stall = burst ? 0 : $urandom_range(0, 8);
      if (rx_taken == HOLD_OFF_AT) stall = HOLD_OFF_CYCLES;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      rx_taken++;
    end
  end

  // Watchdog: any cycle with a request accepted on either channel restarts
  // the count.
  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timeout: no request accepted for %0d cycles", STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    bit drained;
    int directed_count;
    drained = 1'b0;
    rst_n                <= 1'b0;
    in_valid             <= 1'b0;
    in_aux_byte          <= 8'h00;
    in_region_end        <= 1'b0;
    in_drop_mate_quality <= 1'b0;
    in_drop_mate_cigar   <= 1'b0;
    in_drop_mate_score   <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A whole record of droppable fields with every drop flag set: nothing
    // is kept, so the record closes with an empty marker.
    rec_bytes = '{CH_UP_M, CH_UP_Q, CH_UP_C, 8'hFF};
    send_record(3'b111);
    // An MQ string field kept because only the other two flags are set;
    // the record ends on the string terminator.
    rec_bytes = '{CH_UP_M, CH_UP_Q, CH_UP_Z, 8'h80, CH_NUL};
    send_record(3'b110);
    // A region that ends on its first tag byte is truncated.
    rec_bytes = '{8'h61};
    send_record(3'b000);
    // An unknown type code: the error byte and everything after it up to
    // the region end are swallowed.
    rec_bytes = '{CH_LO_M, CH_LO_S, 8'h71, 8'h55, 8'hAA};
    send_record(3'b100);
    // An unknown array subtype, found once the fourth count byte arrives.
    rec_bytes = '{8'h58, 8'h58, CH_UP_B, 8'h78, 8'h01, 8'h00, 8'h00, 8'h00};
    send_record(3'b000);
    directed_count = sent_count;

    while (sent_count < directed_count + RANDOM_REQUESTS) begin
      sender_quiet = ($urandom_range(0, 3) == 0);
      build_record();
      send_record(3'($urandom_range(0, 7)));
      // Once in the run the sender stops until every result is out.
      if (!drained && sent_count >= DRAIN_AT) begin
        drained = 1'b1;
        drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d requests: directed drops, truncation and bad codes, then random records.",
             sent_count);
    $display("Checked %0d results over %0d closed records.", result_count, record_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
